>>> rtl/rotation_source_address_macros.svh
// Assertion macros shared by the rotation source address RTL.
// Expects clk and arst_n in the scope of every use.
`ifndef ROTATION_SOURCE_ADDRESS_MACROS_SVH
`define ROTATION_SOURCE_ADDRESS_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define RSA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define RSA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/rsa_pkg.sv
// Shared constants, types and register codes of the rotation source address block.
// No dependencies; used by rsa_front, rsa_queue, rsa_back and the top level.
`default_nettype none

package rsa_pkg;

	localparam int FRAC_BITS = 16;
	localparam int MAX_DIM   = 2048;
	localparam int SHIFT     = FRAC_BITS + 1;   // half-pixel offsets add one fraction bit

	localparam int COORD_W   = 12;
	localparam int COEF_W    = 18;
	localparam int REG_DIM_W = 12;
	localparam int DIM_W     = $clog2(MAX_DIM + 1);
	localparam int PROD_W    = DIM_W + COEF_W;
	localparam int FSZ_W     = PROD_W + 1 - FRAC_BITS;
	localparam int DX_W      = ((COORD_W + 1 > FSZ_W) ? COORD_W + 1 : FSZ_W) + 1;
	localparam int MUL_W     = DX_W + COEF_W;
	localparam int NX_W      = MUL_W + 2;
	localparam int OX_W      = NX_W - SHIFT;

	localparam int COL_W     = 11;
	localparam int ADDR_W    = 22;
	localparam int AMUL_W    = COL_W + DIM_W;
	localparam int OUT_FSZ_W = 12;
	localparam int FSZ_SAT   = 4095;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = COEF_W;
	localparam int RST_COS    = 1 << FRAC_BITS;
	localparam int RST_SIN    = 0;
	localparam int RST_WIDTH  = 640;
	localparam int RST_HEIGHT = 480;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COS,
		REG_SIN,
		REG_WIDTH,
		REG_HEIGHT
	} reg_idx_t;

	// Live configuration, source size already clamped to MAX_DIM.
	typedef struct packed {
		logic [COEF_W-1:0] cos_v;
		logic [COEF_W-1:0] sin_v;
		logic [DIM_W-1:0]  w;
		logic [DIM_W-1:0]  h;
	} cfg_t;

	// One classified pixel on its way from front to back.
	typedef struct packed {
		logic [DX_W-1:0]  dx;
		logic [DX_W-1:0]  dy;
		logic             outside;
		logic [FSZ_W-1:0] fw;
		logic [FSZ_W-1:0] fh;
	} item_t;

endpackage

`default_nettype wire

>>> rtl/rotation_source_address.sv
// Top level of the rotation source address generator: configuration registers,
// front end, queue and back end. Depends on rsa_pkg, rsa_front, rsa_queue, rsa_back.
//
// Inverse-mapping nearest-neighbour rotation address generator. Feed it the
// (out_x, out_y) raster of the rotated frame, one coordinate per cycle; for each
// transaction it returns one result: the source column and row, the linear source
// address row*width+column, an in_bounds flag (0 means the output pixel is zero),
// an outside_frame flag and the rotated frame size, which saturates at 4095 in the
// result fields. cos/sin are signed Q1.16 written by software; widths above 2048
// clamp to 2048. Throughput is one transaction per cycle unless the output stalls.
// Each transaction passes through two front stages (size products, then frame size
// and centre offsets), the four-entry queue, and four back stages (rotation
// products, rotation sums, bounds check, row*width multiply) into the output
// register. The queue absorbs output stalls so the input keeps accepting until it
// fills. Configuration writes are taken every cycle (cfg_ready is always high) and
// must only happen while no transaction is in flight.
`default_nettype none

module rotation_source_address (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// configuration write channel
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [rsa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [rsa_pkg::CFG_DATA_W-1:0]     cfg_data,
	// coordinate input channel
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [rsa_pkg::COORD_W-1:0]        out_x,
	input  wire logic [rsa_pkg::COORD_W-1:0]        out_y,
	// source address output channel
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic [rsa_pkg::COL_W-1:0]               src_col,
	output logic [rsa_pkg::COL_W-1:0]               src_row,
	output logic [rsa_pkg::ADDR_W-1:0]              src_addr,
	output logic                                    in_bounds,
	output logic                                    outside_frame,
	output logic [rsa_pkg::OUT_FSZ_W-1:0]           frame_width,
	output logic [rsa_pkg::OUT_FSZ_W-1:0]           frame_height
);

	logic [rsa_pkg::COEF_W-1:0]    cos_q, sin_q;
	logic [rsa_pkg::REG_DIM_W-1:0] width_q, height_q;
	rsa_pkg::cfg_t                 cfg;

	logic           q_full, q_empty, push, pop;
	rsa_pkg::item_t push_item, pop_item;

	assign cfg_ready = 1'b1;

	// register file; every 2-bit index maps to a register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_q    <= rsa_pkg::COEF_W'(rsa_pkg::RST_COS);
			sin_q    <= rsa_pkg::COEF_W'(rsa_pkg::RST_SIN);
			width_q  <= rsa_pkg::REG_DIM_W'(rsa_pkg::RST_WIDTH);
			height_q <= rsa_pkg::REG_DIM_W'(rsa_pkg::RST_HEIGHT);
		end else if (cfg_valid && cfg_ready) begin
			unique case (rsa_pkg::reg_idx_t'(cfg_index))
				rsa_pkg::REG_COS:    cos_q    <= cfg_data;
				rsa_pkg::REG_SIN:    sin_q    <= cfg_data;
				rsa_pkg::REG_WIDTH:  width_q  <= cfg_data[rsa_pkg::REG_DIM_W-1:0];
				rsa_pkg::REG_HEIGHT: height_q <= cfg_data[rsa_pkg::REG_DIM_W-1:0];
			endcase
		end
	end

	// clamp the source size to MAX_DIM once, shared by front and back
	always_comb begin
		cfg.cos_v = cos_q;
		cfg.sin_v = sin_q;
		cfg.w = (32'(width_q) > rsa_pkg::MAX_DIM) ?
			rsa_pkg::DIM_W'(rsa_pkg::MAX_DIM) : rsa_pkg::DIM_W'(width_q);
		cfg.h = (32'(height_q) > rsa_pkg::MAX_DIM) ?
			rsa_pkg::DIM_W'(rsa_pkg::MAX_DIM) : rsa_pkg::DIM_W'(height_q);
	end

	rsa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_x     (out_x),
		.out_y     (out_y),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	rsa_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.pop_item  (pop_item),
		.empty     (q_empty)
	);

	rsa_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.q_empty       (q_empty),
		.pop           (pop),
		.pop_item      (pop_item),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.src_col       (src_col),
		.src_row       (src_row),
		.src_addr      (src_addr),
		.in_bounds     (in_bounds),
		.outside_frame (outside_frame),
		.frame_width   (frame_width),
		.frame_height  (frame_height)
	);

endmodule

`default_nettype wire

>>> rtl/rsa_front.sv
// Front end: takes output coordinates, works out the rotated frame size,
// centre offsets and the outside-frame flag. Depends on rsa_pkg.
`default_nettype none

module rsa_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire rsa_pkg::cfg_t cfg,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic [rsa_pkg::COORD_W-1:0] out_x,
	input  wire logic [rsa_pkg::COORD_W-1:0] out_y,
	input  wire logic          q_full,
	output logic               push,
	output rsa_pkg::item_t     push_item
);

	logic [rsa_pkg::COEF_W-1:0]  ac;
	logic [rsa_pkg::COEF_W-1:0]  as;
	logic                        front_en;

	logic                        v_s1;
	logic [rsa_pkg::COORD_W-1:0] x_s1, y_s1;
	logic [rsa_pkg::PROD_W-1:0]  wc_s1, hs_s1, hc_s1, ws_s1;

	logic                        v_s2;
	logic [rsa_pkg::COORD_W-1:0] x_s2, y_s2;
	logic [rsa_pkg::FSZ_W-1:0]   fw_s2, fh_s2;

	logic [rsa_pkg::PROD_W:0]    fw_sum, fh_sum;
	logic signed [rsa_pkg::DX_W-1:0] x2, y2, fwx, fhx;

	// |cos|, |sin|; the most negative code gives 2^17, which still fits
	assign ac = cfg.cos_v[rsa_pkg::COEF_W-1] ?
		(~cfg.cos_v + rsa_pkg::COEF_W'(1)) : cfg.cos_v;
	assign as = cfg.sin_v[rsa_pkg::COEF_W-1] ?
		(~cfg.sin_v + rsa_pkg::COEF_W'(1)) : cfg.sin_v;

	assign front_en = !(v_s2 && q_full);
	assign in_stall = !front_en;
	assign push     = v_s2 && !q_full;

	assign fw_sum = {1'b0, wc_s1} + {1'b0, hs_s1};
	assign fh_sum = {1'b0, hc_s1} + {1'b0, ws_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (front_en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (front_en) begin
			x_s1  <= out_x;
			y_s1  <= out_y;
			wc_s1 <= rsa_pkg::PROD_W'(cfg.w) * rsa_pkg::PROD_W'(ac);
			hs_s1 <= rsa_pkg::PROD_W'(cfg.h) * rsa_pkg::PROD_W'(as);
			hc_s1 <= rsa_pkg::PROD_W'(cfg.h) * rsa_pkg::PROD_W'(ac);
			ws_s1 <= rsa_pkg::PROD_W'(cfg.w) * rsa_pkg::PROD_W'(as);
			x_s2  <= x_s1;
			y_s2  <= y_s1;
			fw_s2 <= fw_sum[rsa_pkg::PROD_W:rsa_pkg::FRAC_BITS];
			fh_s2 <= fh_sum[rsa_pkg::PROD_W:rsa_pkg::FRAC_BITS];
		end
	end

	// offsets from the rotated frame centre, in half pixels
	assign x2  = rsa_pkg::DX_W'({x_s2, 1'b0});
	assign y2  = rsa_pkg::DX_W'({y_s2, 1'b0});
	assign fwx = rsa_pkg::DX_W'(fw_s2);
	assign fhx = rsa_pkg::DX_W'(fh_s2);

	always_comb begin
		push_item.dx      = x2 - fwx;
		push_item.dy      = y2 - fhx;
		push_item.outside = (rsa_pkg::DX_W'(x_s2) >= rsa_pkg::DX_W'(fw_s2)) ||
			(rsa_pkg::DX_W'(y_s2) >= rsa_pkg::DX_W'(fh_s2));
		push_item.fw      = fw_s2;
		push_item.fh      = fh_s2;
	end

endmodule

`default_nettype wire

>>> rtl/rsa_queue.sv
// Short FIFO between front and back; lets either side stall on its own.
// Depends on rsa_pkg and rotation_source_address_macros.svh.
`default_nettype none
`include "rotation_source_address_macros.svh"

module rsa_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire rsa_pkg::item_t push_item,
	output logic                full,
	input  wire logic           pop,
	output rsa_pkg::item_t      pop_item,
	output logic                empty
);

	rsa_pkg::item_t              mem_q [rsa_pkg::QDEPTH];
	logic [rsa_pkg::QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [rsa_pkg::QCNT_W-1:0]  cnt_q;

	assign full     = (cnt_q == rsa_pkg::QCNT_W'(rsa_pkg::QDEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + rsa_pkg::QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + rsa_pkg::QPTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + rsa_pkg::QCNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - rsa_pkg::QCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_item;
	end

	`RSA_ASSERT_IMP(a_no_push_full, push, !full, "queue pushed while full")
	`RSA_ASSERT_IMP(a_no_pop_empty, pop, !empty, "queue popped while empty")

endmodule

`default_nettype wire

>>> rtl/rsa_back.sv
// Back end: inverse rotation, bounds check, linear address and output register.
// Depends on rsa_pkg and rotation_source_address_macros.svh.
`default_nettype none
`include "rotation_source_address_macros.svh"

module rsa_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire rsa_pkg::cfg_t  cfg,
	input  wire logic           q_empty,
	output logic                pop,
	input  wire rsa_pkg::item_t pop_item,
	output logic                out_valid,
	input  wire logic           out_stall,
	output logic [rsa_pkg::COL_W-1:0]     src_col,
	output logic [rsa_pkg::COL_W-1:0]     src_row,
	output logic [rsa_pkg::ADDR_W-1:0]    src_addr,
	output logic                          in_bounds,
	output logic                          outside_frame,
	output logic [rsa_pkg::OUT_FSZ_W-1:0] frame_width,
	output logic [rsa_pkg::OUT_FSZ_W-1:0] frame_height
);

	logic back_en;

	logic signed [rsa_pkg::DX_W-1:0]   dx_h, dy_h;
	logic signed [rsa_pkg::COEF_W-1:0] cos_h, sin_h;

	// stage 1: four products
	logic                              v_s1;
	logic signed [rsa_pkg::MUL_W-1:0]  dxc_s1, dys_s1, dxs_s1, dyc_s1;
	logic                              outside_s1;
	logic [rsa_pkg::FSZ_W-1:0]         fw_s1, fh_s1;

	// stage 2: back-rotated positions, Q.17
	logic                              v_s2;
	logic [rsa_pkg::NX_W-1:0]          nx_s2, ny_s2;
	logic                              outside_s2;
	logic [rsa_pkg::FSZ_W-1:0]         fw_s2, fh_s2;

	// stage 3: bounds and coordinates
	logic                              v_s3;
	logic [rsa_pkg::COL_W-1:0]         col_s3, row_s3;
	logic                              inb_s3, outside_s3;
	logic [rsa_pkg::OUT_FSZ_W-1:0]     fw_s3, fh_s3;

	// stage 4: row times width
	logic                              v_s4;
	logic [rsa_pkg::AMUL_W-1:0]        rw_s4;
	logic [rsa_pkg::COL_W-1:0]         col_s4, row_s4;
	logic                              inb_s4, outside_s4;
	logic [rsa_pkg::OUT_FSZ_W-1:0]     fw_s4, fh_s4;

	logic                              out_valid_q;

	logic                              nx_neg, ny_neg, inx, iny, inb;
	logic [rsa_pkg::OX_W-1:0]          nx_hi, ny_hi;
	logic [rsa_pkg::SHIFT-1:0]         nx_lo, ny_lo;

	assign back_en   = !out_valid_q || !out_stall;
	assign pop       = back_en && !q_empty;
	assign out_valid = out_valid_q;

	assign dx_h  = pop_item.dx;
	assign dy_h  = pop_item.dy;
	assign cos_h = cfg.cos_v;
	assign sin_h = cfg.sin_v;

	// Truncation toward zero: a negative sum above -1 pixel lands on 0.
	assign nx_neg = nx_s2[rsa_pkg::NX_W-1];
	assign ny_neg = ny_s2[rsa_pkg::NX_W-1];
	assign nx_hi  = nx_s2[rsa_pkg::NX_W-1:rsa_pkg::SHIFT];
	assign ny_hi  = ny_s2[rsa_pkg::NX_W-1:rsa_pkg::SHIFT];
	assign nx_lo  = nx_s2[rsa_pkg::SHIFT-1:0];
	assign ny_lo  = ny_s2[rsa_pkg::SHIFT-1:0];
	assign inx = nx_neg ? ((&nx_hi) && (|nx_lo) && (cfg.w != '0)) :
		(nx_hi < rsa_pkg::OX_W'(cfg.w));
	assign iny = ny_neg ? ((&ny_hi) && (|ny_lo) && (cfg.h != '0)) :
		(ny_hi < rsa_pkg::OX_W'(cfg.h));
	assign inb = !outside_s2 && inx && iny;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (back_en) begin
			v_s1        <= pop;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (back_en) begin
			dxc_s1     <= rsa_pkg::MUL_W'(dx_h) * rsa_pkg::MUL_W'(cos_h);
			dys_s1     <= rsa_pkg::MUL_W'(dy_h) * rsa_pkg::MUL_W'(sin_h);
			dxs_s1     <= rsa_pkg::MUL_W'(dx_h) * rsa_pkg::MUL_W'(sin_h);
			dyc_s1     <= rsa_pkg::MUL_W'(dy_h) * rsa_pkg::MUL_W'(cos_h);
			outside_s1 <= pop_item.outside;
			fw_s1      <= pop_item.fw;
			fh_s1      <= pop_item.fh;

			nx_s2 <= rsa_pkg::NX_W'(dxc_s1) + rsa_pkg::NX_W'(dys_s1) +
				rsa_pkg::NX_W'({cfg.w, {rsa_pkg::FRAC_BITS{1'b0}}});
			ny_s2 <= rsa_pkg::NX_W'(dyc_s1) - rsa_pkg::NX_W'(dxs_s1) +
				rsa_pkg::NX_W'({cfg.h, {rsa_pkg::FRAC_BITS{1'b0}}});
			outside_s2 <= outside_s1;
			fw_s2      <= fw_s1;
			fh_s2      <= fh_s1;

			col_s3     <= (inb && !nx_neg) ? nx_hi[rsa_pkg::COL_W-1:0] : '0;
			row_s3     <= (inb && !ny_neg) ? ny_hi[rsa_pkg::COL_W-1:0] : '0;
			inb_s3     <= inb;
			outside_s3 <= outside_s2;
			fw_s3      <= (32'(fw_s2) > rsa_pkg::FSZ_SAT) ?
				rsa_pkg::OUT_FSZ_W'(rsa_pkg::FSZ_SAT) : rsa_pkg::OUT_FSZ_W'(fw_s2);
			fh_s3      <= (32'(fh_s2) > rsa_pkg::FSZ_SAT) ?
				rsa_pkg::OUT_FSZ_W'(rsa_pkg::FSZ_SAT) : rsa_pkg::OUT_FSZ_W'(fh_s2);

			rw_s4      <= rsa_pkg::AMUL_W'(row_s3) * rsa_pkg::AMUL_W'(cfg.w);
			col_s4     <= col_s3;
			row_s4     <= row_s3;
			inb_s4     <= inb_s3;
			outside_s4 <= outside_s3;
			fw_s4      <= fw_s3;
			fh_s4      <= fh_s3;

			src_addr      <= rsa_pkg::ADDR_W'(rw_s4 + rsa_pkg::AMUL_W'(col_s4));
			src_col       <= col_s4;
			src_row       <= row_s4;
			in_bounds     <= inb_s4;
			outside_frame <= outside_s4;
			frame_width   <= fw_s4;
			frame_height  <= fh_s4;
		end
	end

	`RSA_ASSERT_IMP(a_inb_not_outside, out_valid_q && in_bounds, !outside_frame,
		"in_bounds set on a pixel outside the frame")
	`RSA_ASSERT_IMP(a_oob_zero, out_valid_q && !in_bounds,
		(src_addr == '0) && (src_col == '0) && (src_row == '0),
		"out-of-bounds pixel with nonzero source coordinates")
	`RSA_ASSERT_IMP(a_col_in_width, out_valid_q && in_bounds,
		rsa_pkg::DIM_W'(src_col) < cfg.w, "source column beyond width")

endmodule

`default_nettype wire
